FILE: src/gsgc_pkg.sv
package gsgc_pkg;

    localparam int SIG_ENTRIES_DEF = 256;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int VOLT_W     = 16;
    localparam int DIFF_W     = VOLT_W + 1;
    localparam int GATE_W     = 17;
    localparam int CUR_W      = 32;
    localparam int STAT_W     = 2;

    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int PROD_W  = 60;

    localparam int DIV_NUM_W = 34;
    localparam int DIV_DEN_W = 20;
    localparam int DIV_CNT_W = 5;

    localparam int PA_SCALE = 1000;
    localparam logic [GATE_W-1:0] GATE_ONE = 17'h10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE      = 3'd0,
        CFG_CONDUCTANCE = 3'd1,
        CFG_TIME_CONST  = 3'd2,
        CFG_HALF_VOLT   = 3'd3,
        CFG_SLOPE_VOLT  = 3'd4,
        CFG_REV_VOLT    = 3'd5
    } cfg_idx_t;

    typedef enum logic [STAT_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_INACTIVE = 2'd1,
        STATUS_INVALID  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        MUL_HOLD,
        MUL_IDX,
        MUL_DT,
        MUL_CG,
        MUL_GV,
        MUL_LO,
        MUL_HI
    } mul_op_t;

    typedef enum logic {
        DIV_IDX,
        DIV_DT
    } div_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_IDX_GO,
        S_IDX_DIV,
        S_ROM,
        S_DT_MUL,
        S_DT_GO,
        S_DT_DIV,
        S_CG_MUL,
        S_GV_MUL,
        S_LO_MUL,
        S_HI_MUL,
        S_SUM,
        S_ROUND,
        S_DONE
    } fsm_state_t;

    typedef struct packed {
        logic    capture;
        logic    bypass;
        mul_op_t mul_op;
        logic    div_start;
        div_op_t div_op;
        logic    load_idx;
        logic    load_target;
        logic    load_gate;
        logic    load_a;
        logic    load_b;
        logic    load_plo;
        logic    load_prod;
        logic    load_result;
        logic    load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic invalid;
        logic inactive;
        logic div_busy;
    } dp_stat_t;

endpackage

FILE: src/gsgc_if.sv
interface gsgc_in_if;
    import gsgc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [VOLT_W-1:0]        step_size;
    logic signed [VOLT_W-1:0] pre_voltage;
    logic signed [VOLT_W-1:0] post_voltage;

    modport source (output valid, step_size, pre_voltage, post_voltage, input ready);
    modport sink (input valid, step_size, pre_voltage, post_voltage, output ready);
endinterface

interface gsgc_out_if;
    import gsgc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [CUR_W-1:0] current;
    logic signed [CUR_W-1:0] peak_current;
    logic [GATE_W-1:0]       gate_value;
    logic [STAT_W-1:0]       status;

    modport source (output valid, current, peak_current, gate_value, status, input ready);
    modport sink (input valid, current, peak_current, gate_value, status, output ready);
endinterface

FILE: src/graded_synapse_gate_current_core.sv
// Graded chemical synapse, one simulation step per input item: the gate is
// moved toward the logistic of the presynaptic voltage with first-order
// kinetics, then the current 1000*g*s*(E_rev-v_post) in 1/256 pA is formed
// and the signed peak by magnitude is tracked. One item is processed at a
// time; an active valid step spends most of its time in the shared
// divider (two quotient bits per cycle, used for the index and the gate
// divisions) and in the shared 26x17 multiplier, used for six products.
// An inactive or invalid step goes from the check state straight to the
// done state, which loads the output register. A new item is accepted
// while the previous result waits in the output register; a result that
// is still not taken when the next one is done stalls the block.
// Configuration must be written only while no item is in flight.
module graded_synapse_gate_current_core #(
    parameter int SIGMOID_ENTRIES = gsgc_pkg::SIG_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    gsgc_in_if.sink                         in_ch,
    gsgc_out_if.source                      out_ch,
    input  logic                            cfg_we,
    input  logic [gsgc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gsgc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gsgc_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    gsgc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    gsgc_dp #(
        .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .step_size    (in_ch.step_size),
        .pre_voltage  (in_ch.pre_voltage),
        .post_voltage (in_ch.post_voltage),
        .cmd          (cmd),
        .stat         (stat),
        .current      (out_ch.current),
        .peak_current (out_ch.peak_current),
        .gate_value   (out_ch.gate_value),
        .status       (out_ch.status)
    );

endmodule

FILE: src/gsgc_div.sv
module gsgc_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [gsgc_pkg::DIV_NUM_W-1:0] num,
    input  logic [gsgc_pkg::DIV_DEN_W-1:0] den,
    output logic                           busy,
    output logic [gsgc_pkg::DIV_NUM_W-1:0] quo,
    output logic                           rem_nz
);
    import gsgc_pkg::*;

    localparam int DIV_STEPS = DIV_NUM_W / 2;

    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;

    // two restoring steps per cycle
    always_comb
    begin
        logic [DIV_DEN_W:0] trial;
        rem_next = rem_reg;
        quo_next = quo_reg;
        for (int k = 0; k < 2; k++)
        begin
            trial    = {rem_next, quo_next[DIV_NUM_W-1]};
            quo_next = {quo_next[DIV_NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next    = DIV_DEN_W'(trial - {1'b0, den_reg});
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[DIV_DEN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy   = busy_reg;
    assign quo    = quo_reg;
    assign rem_nz = (rem_reg != '0);

endmodule

FILE: src/gsgc_ctrl.sv
module gsgc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  gsgc_pkg::dp_stat_t stat,
    output gsgc_pkg::dp_cmd_t  cmd
);
    import gsgc_pkg::*;

    fsm_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:    if (in_valid) state_next = S_CHECK;
            S_CHECK:   state_next = (stat.invalid || stat.inactive) ? S_DONE : S_IDX_GO;
            S_IDX_GO:  state_next = S_IDX_DIV;
            S_IDX_DIV: if (!stat.div_busy) state_next = S_ROM;
            S_ROM:     state_next = S_DT_MUL;
            S_DT_MUL:  state_next = S_DT_GO;
            S_DT_GO:   state_next = S_DT_DIV;
            S_DT_DIV:  if (!stat.div_busy) state_next = S_CG_MUL;
            S_CG_MUL:  state_next = S_GV_MUL;
            S_GV_MUL:  state_next = S_LO_MUL;
            S_LO_MUL:  state_next = S_HI_MUL;
            S_HI_MUL:  state_next = S_SUM;
            S_SUM:     state_next = S_ROUND;
            S_ROUND:   state_next = S_DONE;
            S_DONE:    if (out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.mul_op = MUL_HOLD;
        cmd.div_op = DIV_IDX;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_CHECK:
            begin
                if (stat.invalid || stat.inactive)
                    cmd.bypass = 1'b1;
                else
                    cmd.mul_op = MUL_IDX;
            end
            S_IDX_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_IDX;
            end
            S_IDX_DIV: cmd.load_idx = !stat.div_busy;
            S_ROM:     cmd.load_target = 1'b1;
            S_DT_MUL:  cmd.mul_op = MUL_DT;
            S_DT_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_DT;
            end
            S_DT_DIV:  cmd.load_gate = !stat.div_busy;
            S_CG_MUL:  cmd.mul_op = MUL_CG;
            S_GV_MUL:
            begin
                cmd.mul_op = MUL_GV;
                cmd.load_a = 1'b1;
            end
            S_LO_MUL:
            begin
                cmd.mul_op = MUL_LO;
                cmd.load_b = 1'b1;
            end
            S_HI_MUL:
            begin
                cmd.mul_op   = MUL_HI;
                cmd.load_plo = 1'b1;
            end
            S_SUM:     cmd.load_prod = 1'b1;
            S_ROUND:   cmd.load_result = 1'b1;
            S_DONE:    cmd.load_out = out_free;
            default:   cmd.mul_op = MUL_HOLD;
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: src/gsgc_dp.sv
module gsgc_dp #(
    parameter int SIGMOID_ENTRIES = gsgc_pkg::SIG_ENTRIES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [gsgc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gsgc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [gsgc_pkg::VOLT_W-1:0]      step_size,
    input  logic signed [gsgc_pkg::VOLT_W-1:0] pre_voltage,
    input  logic signed [gsgc_pkg::VOLT_W-1:0] post_voltage,
    input  gsgc_pkg::dp_cmd_t                cmd,
    output gsgc_pkg::dp_stat_t               stat,
    output logic signed [gsgc_pkg::CUR_W-1:0] current,
    output logic signed [gsgc_pkg::CUR_W-1:0] peak_current,
    output logic [gsgc_pkg::GATE_W-1:0]      gate_value,
    output logic [gsgc_pkg::STAT_W-1:0]      status
);
    import gsgc_pkg::*;

    localparam int HALF  = SIGMOID_ENTRIES / 2;
    localparam int IDX_W = $clog2(SIGMOID_ENTRIES);
    localparam logic signed [31:0] HALF_S = 32'(HALF);
    localparam logic signed [31:0] LAST_S = 32'(SIGMOID_ENTRIES - 1);

    // shift-subtract quotient for table generation
    function automatic longint unsigned udiv(input longint unsigned num_v,
                                             input longint unsigned den_v);
        longint unsigned q, r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], num_v[b]};
            if (r >= den_v)
            begin
                r    = r - den_v;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // logistic entry for x = 16*(idx - half)/entries, Q1.16
    function automatic logic [GATE_W-1:0] sig_entry(input int idx);
        longint unsigned m, y, term, e, d, r;
        longint          sum;
        bit              pos;
        pos  = (idx >= HALF);
        m    = pos ? 64'(idx - HALF) : 64'(HALF - idx);
        y    = udiv(m << 31, 64'(SIGMOID_ENTRIES));
        term = 64'd1 << 30;
        sum  = longint'(64'd1 << 30);
        for (int unsigned n = 1; n <= 20; n++)
        begin
            term = udiv((term * y) >> 30, 64'(n));
            if (n[0])
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > longint'(64'd1 << 30))
            sum = longint'(64'd1 << 30);
        e = 64'(sum);
        for (int n = 0; n < 3; n++)
            e = (e * e + (64'd1 << 29)) >> 30;
        d = (64'd1 << 30) + e;
        if (pos)
            r = udiv((64'd1 << 46) + (d >> 1), d);
        else
            r = udiv((e << 16) + (d >> 1), d);
        return GATE_W'(r);
    endfunction

    logic [GATE_W-1:0] sig_rom [SIGMOID_ENTRIES];

    for (genvar g = 0; g < SIGMOID_ENTRIES; g++)
    begin : g_rom
        localparam logic [GATE_W-1:0] ENTRY = sig_entry(g);
        assign sig_rom[g] = ENTRY;
    end

    // configuration
    logic                     enable_reg;
    logic [VOLT_W-1:0]        cond_reg;
    logic [VOLT_W-1:0]        tau_reg;
    logic signed [VOLT_W-1:0] half_reg;
    logic signed [VOLT_W-1:0] slope_reg;
    logic signed [VOLT_W-1:0] rev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
            cond_reg   <= 16'd4096;
            tau_reg    <= 16'd2560;
            half_reg   <= -16'sd5120;
            slope_reg  <= 16'sd1280;
            rev_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENABLE:      enable_reg <= cfg_data[0];
                CFG_CONDUCTANCE: cond_reg   <= cfg_data;
                CFG_TIME_CONST:  tau_reg    <= cfg_data;
                CFG_HALF_VOLT:   half_reg   <= cfg_data;
                CFG_SLOPE_VOLT:  slope_reg  <= cfg_data;
                CFG_REV_VOLT:    rev_reg    <= cfg_data;
                default:         enable_reg <= enable_reg;
            endcase
        end
    end

    // captured item
    logic [VOLT_W-1:0]        dt_reg;
    logic signed [DIFF_W-1:0] vdiff_reg;
    logic signed [DIFF_W-1:0] dv_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            dt_reg    <= step_size;
            vdiff_reg <= DIFF_W'(pre_voltage) - DIFF_W'(half_reg);
            dv_reg    <= DIFF_W'(rev_reg) - DIFF_W'(post_voltage);
        end
    end

    logic [VOLT_W-1:0]      vdiff_mag, dv_mag, slope_mag;
    logic signed [GATE_W:0] tdiff;
    logic [GATE_W-1:0]      tdiff_mag;
    logic [IDX_W-1:0]       idx_reg;
    logic [GATE_W-1:0]      target_reg;
    logic [GATE_W-1:0]      gate_reg;

    assign vdiff_mag = VOLT_W'(vdiff_reg[DIFF_W-1] ? -vdiff_reg : vdiff_reg);
    assign dv_mag    = VOLT_W'(dv_reg[DIFF_W-1] ? -dv_reg : dv_reg);
    assign slope_mag = VOLT_W'(slope_reg[VOLT_W-1] ? -DIFF_W'(slope_reg) : DIFF_W'(slope_reg));
    assign tdiff     = $signed({1'b0, target_reg}) - $signed({1'b0, gate_reg});
    assign tdiff_mag = GATE_W'(tdiff[GATE_W] ? -tdiff : tdiff);

    // shared multiplier
    logic [MUL_A_W-1:0] mul_a, a_reg;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p, mul_reg, plo_reg;
    logic [VOLT_W-1:0]  bhi_reg;

    always_comb
    begin
        case (cmd.mul_op)
            MUL_IDX:
            begin
                mul_a = MUL_A_W'(SIGMOID_ENTRIES);
                mul_b = MUL_B_W'(vdiff_mag);
            end
            MUL_DT:
            begin
                mul_a = MUL_A_W'(dt_reg);
                mul_b = tdiff_mag;
            end
            MUL_CG:
            begin
                mul_a = MUL_A_W'(cond_reg);
                mul_b = MUL_B_W'(PA_SCALE);
            end
            MUL_GV:
            begin
                mul_a = MUL_A_W'(dv_mag);
                mul_b = gate_reg;
            end
            MUL_LO:
            begin
                mul_a = a_reg;
                mul_b = mul_reg[MUL_B_W-1:0];
            end
            MUL_HI:
            begin
                mul_a = a_reg;
                mul_b = MUL_B_W'(bhi_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_op != MUL_HOLD)
            mul_reg <= mul_p;
        if (cmd.load_a)
            a_reg <= mul_reg[MUL_A_W-1:0];
        if (cmd.load_b)
            bhi_reg <= mul_reg[MUL_B_W+VOLT_W-1:MUL_B_W];
        if (cmd.load_plo)
            plo_reg <= mul_reg;
    end

    // shared divider
    logic [DIV_NUM_W-1:0] div_num, div_quo;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_busy, div_rnz;

    always_comb
    begin
        case (cmd.div_op)
            DIV_DT:
            begin
                div_num = DIV_NUM_W'(mul_reg) + DIV_NUM_W'({tau_reg, 3'b000});
                div_den = {tau_reg, 4'b0000};
            end
            default:
            begin
                div_num = DIV_NUM_W'(mul_reg);
                div_den = {slope_mag, 4'b0000};
            end
        endcase
    end

    gsgc_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.div_start),
        .num    (div_num),
        .den    (div_den),
        .busy   (div_busy),
        .quo    (div_quo),
        .rem_nz (div_rnz)
    );

    // floor quotient to table index
    logic              idx_neg;
    logic [29:0]       q_mag;
    logic signed [31:0] q_s, idx_s;
    logic [IDX_W-1:0]  idx_c;

    assign idx_neg = vdiff_reg[DIFF_W-1] ^ slope_reg[VOLT_W-1];

    always_comb
    begin
        q_mag = 30'(div_quo[28:0]) + 30'(idx_neg & div_rnz);
        q_s   = idx_neg ? -$signed({2'b00, q_mag}) : $signed({2'b00, q_mag});
        idx_s = q_s + HALF_S;
        if (idx_s < 0)
            idx_c = '0;
        else if (idx_s > LAST_S)
            idx_c = LAST_S[IDX_W-1:0];
        else
            idx_c = idx_s[IDX_W-1:0];
    end

    // gate update with clamp to [0, 1]
    logic signed [31:0] dq_s, g_sum;
    logic [GATE_W-1:0]  gate_c;

    always_comb
    begin
        dq_s  = $signed({2'b00, div_quo[29:0]});
        g_sum = $signed({15'b0, gate_reg}) + (tdiff[GATE_W] ? -dq_s : dq_s);
        if (g_sum < 0)
            gate_c = '0;
        else if (g_sum > $signed({15'b0, GATE_ONE}))
            gate_c = GATE_ONE;
        else
            gate_c = g_sum[GATE_W-1:0];
    end

    // current rounding and saturation
    logic [PROD_W-1:0] prod_reg, prod_rnd;
    logic [CUR_W-1:0]  cur_mag, cur_c;
    logic [CUR_W-2:0]  mag31;

    always_comb
    begin
        prod_rnd = prod_reg + (PROD_W'(1) << 27);
        cur_mag  = prod_rnd[CUR_W+27:28];
        if (!dv_reg[DIFF_W-1])
            cur_c = (cur_mag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : cur_mag;
        else
            cur_c = (cur_mag > 32'h8000_0000) ? 32'h8000_0000 : -cur_mag;
        mag31 = (cur_mag > 32'h7FFF_FFFF) ? 31'h7FFF_FFFF : cur_mag[CUR_W-2:0];
    end

    logic [CUR_W-2:0]        peak_mag_reg;
    logic signed [CUR_W-1:0] peak_signed_reg;
    logic [CUR_W-1:0]        res_current_reg;
    status_t                 res_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_reg        <= '0;
            peak_mag_reg    <= '0;
            peak_signed_reg <= '0;
        end
        else
        begin
            if (cmd.load_gate)
                gate_reg <= gate_c;
            if (cmd.load_result && (mag31 > peak_mag_reg))
            begin
                peak_mag_reg    <= mag31;
                peak_signed_reg <= cur_c;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_idx)
            idx_reg <= idx_c;
        if (cmd.load_target)
            target_reg <= sig_rom[idx_reg];
        if (cmd.load_prod)
            prod_reg <= PROD_W'(plo_reg) + (PROD_W'(mul_reg) << MUL_B_W);
        if (cmd.bypass)
        begin
            res_current_reg <= '0;
            res_status_reg  <= stat.invalid ? STATUS_INVALID : STATUS_INACTIVE;
        end
        else if (cmd.load_result)
        begin
            res_current_reg <= cur_c;
            res_status_reg  <= STATUS_OK;
        end
    end

    // output register
    logic signed [CUR_W-1:0] out_current_reg, out_peak_reg;
    logic [GATE_W-1:0]       out_gate_reg;
    logic [STAT_W-1:0]       out_status_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_current_reg <= res_current_reg;
            out_peak_reg    <= peak_signed_reg;
            out_gate_reg    <= gate_reg;
            out_status_reg  <= res_status_reg;
        end
    end

    assign stat.invalid  = (dt_reg == '0) || (slope_reg == '0) || (tau_reg == '0);
    assign stat.inactive = !enable_reg;
    assign stat.div_busy = div_busy;

    assign current      = out_current_reg;
    assign peak_current = out_peak_reg;
    assign gate_value   = out_gate_reg;
    assign status       = out_status_reg;

endmodule

FILE: src/gsgc_checker.sv
module gsgc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic signed [gsgc_pkg::CUR_W-1:0] current,
    input logic signed [gsgc_pkg::CUR_W-1:0] peak_current,
    input logic [gsgc_pkg::GATE_W-1:0]      gate_value,
    input logic [gsgc_pkg::STAT_W-1:0]      status
);
    import gsgc_pkg::*;

    logic [CUR_W-1:0] cur_abs, peak_abs, cur_sat, peak_sat;

    assign cur_abs  = current[CUR_W-1] ? CUR_W'(-current) : CUR_W'(current);
    assign peak_abs = peak_current[CUR_W-1] ? CUR_W'(-peak_current) : CUR_W'(peak_current);
    assign cur_sat  = (cur_abs > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : cur_abs;
    assign peak_sat = (peak_abs > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : peak_abs;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(current) && $stable(peak_current)
            && $stable(gate_value) && $stable(status))
        else $error("result changed while stalled");

    // no current on a skipped step
    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STATUS_OK) |-> (current == 0))
        else $error("nonzero current on inactive or invalid step");

    a_gate_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (gate_value <= GATE_ONE)
            && (status == STATUS_OK || status == STATUS_INACTIVE || status == STATUS_INVALID))
        else $error("gate or status out of range");

    // peak covers the current of a computed step
    a_peak_cover: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_OK) |-> (peak_sat >= cur_sat))
        else $error("peak smaller than current");

endmodule

bind graded_synapse_gate_current_core gsgc_checker u_gsgc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .current      (out_ch.current),
    .peak_current (out_ch.peak_current),
    .gate_value   (out_ch.gate_value),
    .status       (out_ch.status)
);
